// ----- hdl/spnh_pkg.sv -----
package spnh_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int EPS_W           = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd66;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ELOAD,
        S_EMUL,
        S_EACC,
        S_CHK,
        S_CLOAD1,
        S_CMUL1,
        S_CSAVE,
        S_CMUL2,
        S_CCMP,
        S_NEXT,
        S_PLOAD,
        S_PMUL,
        S_DLOAD,
        S_PDIV,
        S_PSAVE,
        S_OUT
    } t_state;

    // products that build the three cross terms of one edge
    typedef enum logic [2:0] {
        MOP_C_POS,
        MOP_C_NEG,
        MOP_N0_POS,
        MOP_N0_NEG,
        MOP_N1_POS,
        MOP_N1_NEG
    } t_mop;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_VERTEX = 1'b1
    } t_kind;

endpackage

// ----- hdl/segment_polygon_nearest_hit.sv -----
// Nearest crossing of a query segment with a closed polygon.
// Input channel (i_in_valid / o_in_stall): a start transaction (i_kind = 0)
// loads the segment P=(i_px,i_py) to Q=(i_qx,i_qy); vertex transactions
// (i_kind = 1) stream the polygon, and the one with i_last set closes the
// polygon back to its first vertex and produces one result.
// Output channel (o_out_valid / i_out_stall): o_hit, o_hit_x, o_hit_y.
// Config channel (i_cfg_valid / o_cfg_ready): write i_cfg_data to the
// parallel threshold on |cross| (raw Q32.32); ready is always high.
// One shared bit-serial shift-add multiplier (one multiplier bit a cycle)
// and a restoring divider (one quotient bit a cycle) do all the arithmetic.
// Each polygon side runs six products for its cross terms, plus two more when it
// must be ranked against an earlier crossing. A last vertex adds the closing
// side and, on a hit, one multiply and one divide per axis for the point.
// The block takes one transaction at a time; o_in_stall is high
// while it works. The result sits in an output register and holds while
// i_out_stall is high. Synchronous reset clears the segment, the polygon
// state and the output valid, and sets the threshold to 66.
module segment_polygon_nearest_hit
    import spnh_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic signed [FIELD_W-1:0] i_px,
    input  logic signed [FIELD_W-1:0] i_py,
    input  logic signed [FIELD_W-1:0] i_qx,
    input  logic signed [FIELD_W-1:0] i_qy,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    output logic signed [FIELD_W-1:0] o_hit_x,
    output logic signed [FIELD_W-1:0] o_hit_y,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [EPS_W-1:0]          i_cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int MW   = 2 * DW;
    localparam int XW   = MW + 1;
    localparam int PW   = 2 * MW;
    localparam int CNTW = $clog2(PW + 1);

    function automatic logic [DW-1:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        diff = {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic logic [MW-1:0] mag(input logic [DW-1:0] a);
        logic [DW-1:0] m;
        m   = a[DW-1] ? (~a + 1'b1) : a;
        mag = MW'(m);
    endfunction

    t_state r_state, n_state;

    logic [EPS_W-1:0] r_eps;
    logic [CW-1:0]    r_px, r_py, r_qx, r_qy;
    logic [CW-1:0]    r_fx, r_fy, r_vx, r_vy;
    logic [CW-1:0]    r_ax, r_ay, r_bx, r_by;
    logic             r_have, r_found, r_close, r_fin, r_axis;
    logic [MW-1:0]    r_bnum, r_bden;
    logic [XW-1:0]    r_xc, r_xn0, r_xn1;
    t_mop             r_op;
    logic             r_psgn;
    logic [MW-1:0]    r_ma, r_mb, r_lo;
    logic [MW:0]      r_hi;
    logic [CNTW-1:0]  r_cnt;
    logic [PW-1:0]    r_t, r_dvd;
    logic [MW-1:0]    r_rem;
    logic [FIELD_W-1:0] r_q, r_rx, r_ry;
    logic             r_out_valid, r_hit;
    logic [FIELD_W-1:0] r_hx, r_hy;

    logic w_accept, w_out_free, w_mstep, w_dstep, w_cnt_last, w_ok, w_less;
    logic [DW-1:0] w_d0x, w_d0y, w_d1x, w_d1y, w_rx, w_ry, w_opx, w_opy, w_pd;
    logic [CW-1:0] w_pstart;
    logic [MW:0]   w_sum, w_sh, w_dif;
    logic          w_ge;
    logic [XW-1:0] w_prod, w_cm, w_n0s, w_n1s;
    logic [PW-1:0] w_full;
    logic [FIELD_W-1:0] w_off, w_pval;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_last = (r_cnt == CNTW'(1));

    assign w_d0x = diff(r_qx, r_px);
    assign w_d0y = diff(r_qy, r_py);
    assign w_d1x = diff(r_bx, r_ax);
    assign w_d1y = diff(r_by, r_ay);
    assign w_rx  = diff(r_ax, r_px);
    assign w_ry  = diff(r_ay, r_py);

    always_comb begin
        case (r_op)
            MOP_C_POS:  begin w_opx = w_d0x; w_opy = w_d1y; end
            MOP_C_NEG:  begin w_opx = w_d0y; w_opy = w_d1x; end
            MOP_N0_POS: begin w_opx = w_rx;  w_opy = w_d1y; end
            MOP_N0_NEG: begin w_opx = w_ry;  w_opy = w_d1x; end
            MOP_N1_POS: begin w_opx = w_rx;  w_opy = w_d0y; end
            MOP_N1_NEG: begin w_opx = w_ry;  w_opy = w_d0x; end
            default:    begin w_opx = '0;    w_opy = '0;    end
        endcase
    end

    // serial multiplier: one bit of r_mb a cycle, product shifts down into r_lo
    assign w_sum  = r_hi + (r_mb[0] ? {1'b0, r_ma} : '0);
    assign w_full = {r_hi[MW-1:0], r_lo};
    assign w_prod = r_psgn ? (~{1'b0, r_lo} + 1'b1) : {1'b0, r_lo};

    // restoring divider step
    assign w_sh  = {r_rem, r_dvd[PW-1]};
    assign w_dif = w_sh - {1'b0, r_bden};
    assign w_ge  = !w_dif[MW];

    assign w_cm  = r_xc[XW-1]  ? (~r_xc + 1'b1)  : r_xc;
    assign w_n0s = r_xc[XW-1]  ? (~r_xn0 + 1'b1) : r_xn0;
    assign w_n1s = r_xc[XW-1]  ? (~r_xn1 + 1'b1) : r_xn1;
    assign w_ok  = (w_cm != '0) && (w_cm >= XW'(r_eps))
                 && !w_n0s[XW-1] && (w_n0s <= w_cm)
                 && !w_n1s[XW-1] && (w_n1s <= w_cm);
    assign w_less = (r_t < w_full);

    assign w_pd     = r_axis ? w_d0y : w_d0x;
    assign w_pstart = r_axis ? r_py : r_px;
    assign w_off    = w_pd[DW-1] ? (~r_q + 1'b1) : r_q;
    assign w_pval   = FIELD_W'($signed(w_pstart)) + w_off;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_kind == KIND_VERTEX) begin
                    if (r_have)      n_state = S_ELOAD;
                    else if (i_last) n_state = S_NEXT;
                end
            end
            S_ELOAD:  n_state = S_EMUL;
            S_EMUL:   if (w_cnt_last) n_state = S_EACC;
            S_EACC:   n_state = (r_op == MOP_N1_NEG) ? S_CHK : S_ELOAD;
            S_CHK:    n_state = (w_ok && r_found) ? S_CLOAD1 : S_NEXT;
            S_CLOAD1: n_state = S_CMUL1;
            S_CMUL1:  if (w_cnt_last) n_state = S_CSAVE;
            S_CSAVE:  n_state = S_CMUL2;
            S_CMUL2:  if (w_cnt_last) n_state = S_CCMP;
            S_CCMP:   n_state = S_NEXT;
            S_NEXT: begin
                if (r_close)      n_state = S_ELOAD;
                else if (r_fin)   n_state = r_found ? S_PLOAD : S_OUT;
                else              n_state = S_IDLE;
            end
            S_PLOAD:  n_state = S_PMUL;
            S_PMUL:   if (w_cnt_last) n_state = S_DLOAD;
            S_DLOAD:  n_state = S_PDIV;
            S_PDIV:   if (w_cnt_last) n_state = S_PSAVE;
            S_PSAVE:  n_state = r_axis ? S_OUT : S_PLOAD;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_cfg_ready = 1'b1;
        w_mstep     = (r_state inside {S_EMUL, S_CMUL1, S_CMUL2, S_PMUL});
        w_dstep     = (r_state == S_PDIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eps       <= EPS_RESET;
            r_px        <= '0;
            r_py        <= '0;
            r_qx        <= '0;
            r_qy        <= '0;
            r_have      <= 1'b0;
            r_found     <= 1'b0;
            r_close     <= 1'b0;
            r_fin       <= 1'b0;
            r_bnum      <= '0;
            r_bden      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_eps <= i_cfg_data;
            if (r_state == S_OUT && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            if (w_mstep) begin
                r_hi  <= {1'b0, w_sum[MW:1]};
                r_lo  <= {w_sum[0], r_lo[MW-1:1]};
                r_mb  <= r_mb >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_dstep) begin
                r_rem <= w_ge ? w_dif[MW-1:0] : w_sh[MW-1:0];
                r_dvd <= r_dvd << 1;
                r_q   <= {r_q[FIELD_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_kind == KIND_START) begin
                            r_px    <= i_px[CW-1:0];
                            r_py    <= i_py[CW-1:0];
                            r_qx    <= i_qx[CW-1:0];
                            r_qy    <= i_qy[CW-1:0];
                            r_have  <= 1'b0;
                            r_found <= 1'b0;
                            r_bnum  <= '0;
                            r_bden  <= '0;
                        end else begin
                            r_vx   <= i_px[CW-1:0];
                            r_vy   <= i_py[CW-1:0];
                            r_have <= 1'b1;
                            r_ax   <= r_vx;
                            r_ay   <= r_vy;
                            r_bx   <= i_px[CW-1:0];
                            r_by   <= i_py[CW-1:0];
                            r_op   <= MOP_C_POS;
                            r_xc   <= '0;
                            r_xn0  <= '0;
                            r_xn1  <= '0;
                            r_close <= r_have && i_last;
                            r_fin   <= i_last;
                            if (!r_have) begin
                                r_fx <= i_px[CW-1:0];
                                r_fy <= i_py[CW-1:0];
                            end
                        end
                    end
                end
                S_ELOAD: begin
                    r_ma   <= mag(w_opx);
                    r_mb   <= mag(w_opy);
                    r_psgn <= w_opx[DW-1] ^ w_opy[DW-1];
                    r_hi   <= '0;
                    r_lo   <= '0;
                    r_cnt  <= CNTW'(MW);
                end
                S_EACC: begin
                    case (r_op)
                        MOP_C_POS:  r_xc  <= r_xc + w_prod;
                        MOP_C_NEG:  r_xc  <= r_xc - w_prod;
                        MOP_N0_POS: r_xn0 <= r_xn0 + w_prod;
                        MOP_N0_NEG: r_xn0 <= r_xn0 - w_prod;
                        MOP_N1_POS: r_xn1 <= r_xn1 + w_prod;
                        MOP_N1_NEG: r_xn1 <= r_xn1 - w_prod;
                        default:    r_xc  <= r_xc;
                    endcase
                    if (r_op != MOP_N1_NEG) r_op <= t_mop'(r_op + 3'd1);
                end
                S_CHK: begin
                    if (w_ok && !r_found) begin
                        r_found <= 1'b1;
                        r_bnum  <= w_n0s[MW-1:0];
                        r_bden  <= w_cm[MW-1:0];
                    end
                end
                S_CLOAD1: begin
                    r_ma  <= w_n0s[MW-1:0];
                    r_mb  <= r_bden;
                    r_hi  <= '0;
                    r_lo  <= '0;
                    r_cnt <= CNTW'(MW);
                end
                S_CSAVE: begin
                    r_t   <= w_full;
                    r_ma  <= r_bnum;
                    r_mb  <= w_cm[MW-1:0];
                    r_hi  <= '0;
                    r_lo  <= '0;
                    r_cnt <= CNTW'(MW);
                end
                S_CCMP: begin
                    // strictly nearer crossing replaces the kept one
                    if (w_less) begin
                        r_bnum <= w_n0s[MW-1:0];
                        r_bden <= w_cm[MW-1:0];
                    end
                end
                S_NEXT: begin
                    r_axis <= 1'b0;
                    if (r_close) begin
                        r_close <= 1'b0;
                        r_ax    <= r_vx;
                        r_ay    <= r_vy;
                        r_bx    <= r_fx;
                        r_by    <= r_fy;
                        r_op    <= MOP_C_POS;
                        r_xc    <= '0;
                        r_xn0   <= '0;
                        r_xn1   <= '0;
                    end
                end
                S_PLOAD: begin
                    r_ma  <= mag(w_pd);
                    r_mb  <= r_bnum;
                    r_hi  <= '0;
                    r_lo  <= '0;
                    r_cnt <= CNTW'(MW);
                end
                S_DLOAD: begin
                    r_dvd <= w_full;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_cnt <= CNTW'(PW);
                end
                S_PSAVE: begin
                    if (r_axis) r_ry <= w_pval;
                    else        r_rx <= w_pval;
                    r_axis <= 1'b1;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_hit       <= r_found;
                        r_hx        <= r_found ? r_rx : '0;
                        r_hy        <= r_found ? r_ry : '0;
                        r_have      <= 1'b0;
                        r_found     <= 1'b0;
                        r_fin       <= 1'b0;
                        r_bnum      <= '0;
                        r_bden      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_x     = r_hx;
    assign o_hit_y     = r_hy;

endmodule

// ----- hdl/spnh_checker.sv -----
module spnh_checker
    import spnh_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      i_kind,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_hit,
    input logic signed [FIELD_W-1:0] o_hit_x,
    input logic signed [FIELD_W-1:0] o_hit_y
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit)
            && $stable(o_hit_x) && $stable(o_hit_y))
        else $error("stalled result changed");

    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind == KIND_START |=> !$rose(o_out_valid))
        else $error("start transaction produced a result");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_hit_x == '0 && o_hit_y == '0)
        else $error("miss with nonzero point");

endmodule

bind segment_polygon_nearest_hit spnh_checker u_spnh_checker (.*);

// ----- tb/segment_polygon_nearest_hit_tb.sv -----
`timescale 1ns / 100ps

module segment_polygon_nearest_hit_tb;
    import spnh_pkg::*;

    localparam int  DRAIN_CYCLES = 2000;
    localparam longint CYCLE_LIMIT = 8_000_000;

    typedef logic signed [159:0] wide_t;

    typedef struct packed {
        t_kind             kind;
        logic [FIELD_W-1:0] px;
        logic [FIELD_W-1:0] py;
        logic [FIELD_W-1:0] qx;
        logic [FIELD_W-1:0] qy;
        logic              last;
    } poly_item_t;

    typedef struct packed {
        logic              hit;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
    } hit_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [EPS_W-1:0] i_cfg_data = '0;
    logic o_in_stall, o_out_valid, o_hit, o_cfg_ready;
    logic signed [FIELD_W-1:0] o_hit_x, o_hit_y;

    poly_item_t cur_item = '0;
    poly_item_t pending_items[$];
    hit_t       expected_hits[$];

    logic in_fire = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned errors = 0;
    int unsigned items_queued = 0;
    longint cycle_count = 0;

    // predictor state
    logic [EPS_W-1:0] eps_model = EPS_RESET;
    wide_t seg_p[2], seg_q[2], first_v[2], prev_v[2];
    logic  have_v, best_found;
    wide_t best_num, best_den;

    always #4 i_clk = ~i_clk;

    segment_polygon_nearest_hit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (cur_item.kind),
        .i_px        (cur_item.px),
        .i_py        (cur_item.py),
        .i_qx        (cur_item.qx),
        .i_qy        (cur_item.qy),
        .i_last      (cur_item.last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_hit_x     (o_hit_x),
        .o_hit_y     (o_hit_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic wide_t sext(logic [FIELD_W-1:0] v);
        return wide_t'($signed(v));
    endfunction

    function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        return ax * by - ay * bx;
    endfunction

    task automatic rank_edge(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        wide_t d0x, d0y, d1x, d1y, rx, ry, c, n0, n1;
        d0x = seg_q[0] - seg_p[0];
        d0y = seg_q[1] - seg_p[1];
        d1x = bx - ax;
        d1y = by - ay;
        rx  = ax - seg_p[0];
        ry  = ay - seg_p[1];
        c   = cross2(d0x, d0y, d1x, d1y);
        n0  = cross2(rx, ry, d1x, d1y);
        n1  = cross2(rx, ry, d0x, d0y);
        // normalize so the denominator is positive
        if (c < 0) begin
            c  = -c;
            n0 = -n0;
            n1 = -n1;
        end
        if (c == 0 || c < wide_t'(eps_model)) return;
        if (n0 < 0 || n0 > c || n1 < 0 || n1 > c) return;
        if (!best_found || n0 * best_den < best_num * c) begin
            best_found = 1'b1;
            best_num   = n0;
            best_den   = c;
        end
    endtask

    function automatic logic [FIELD_W-1:0] hit_coord(int axis);
        wide_t d, q, off, v;
        d   = seg_q[axis] - seg_p[axis];
        q   = ((d < 0) ? -d : d) * best_num / best_den;
        off = q & wide_t'(36'hF_FFFF_FFFF);
        v   = seg_p[axis] + ((d < 0) ? -off : off);
        return v[FIELD_W-1:0];
    endfunction

    task automatic clear_polygon();
        have_v     = 1'b0;
        best_found = 1'b0;
        best_num   = 0;
        best_den   = 0;
    endtask

    task automatic predict_polygon(poly_item_t it);
        wide_t vx, vy;
        hit_t  res;
        vx = sext(it.px);
        vy = sext(it.py);
        if (it.kind == KIND_START) begin
            seg_p[0] = vx;
            seg_p[1] = vy;
            seg_q[0] = sext(it.qx);
            seg_q[1] = sext(it.qy);
            clear_polygon();
            return;
        end
        if (have_v) begin
            rank_edge(prev_v[0], prev_v[1], vx, vy);
        end else begin
            first_v[0] = vx;
            first_v[1] = vy;
        end
        prev_v[0] = vx;
        prev_v[1] = vy;
        have_v = 1'b1;
        if (!it.last) return;
        rank_edge(vx, vy, first_v[0], first_v[1]);
        res.hit = best_found;
        res.x   = best_found ? hit_coord(0) : '0;
        res.y   = best_found ? hit_coord(1) : '0;
        expected_hits.push_back(res);
        clear_polygon();
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item   <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // acceptance, prediction and result check
    always @(posedge i_clk) begin
        hit_t exp_hit;
        cycle_count <= cycle_count + 1;
        in_fire <= i_in_valid && !o_in_stall && i_rst_n;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) eps_model <= i_cfg_data;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_polygon(cur_item);
            items_taken <= items_taken + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result hit=%0b x=%h y=%h",
                         $time, o_hit, o_hit_x, o_hit_y);
                errors++;
            end else begin
                exp_hit = expected_hits.pop_front();
                if (exp_hit.hit) hits_seen <= hits_seen + 1;
                if (o_hit !== exp_hit.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_hit.hit, o_hit);
                    errors++;
                end
                if (o_hit_x !== exp_hit.x) begin
                    $display("%0t: hit_x expected %h actual %h", $time, exp_hit.x, o_hit_x);
                    errors++;
                end
                if (o_hit_y !== exp_hit.y) begin
                    $display("%0t: hit_y expected %h actual %h", $time, exp_hit.y, o_hit_y);
                    errors++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] rnd_coord(int unsigned span);
        longint v;
        if (span == 0) return $urandom;
        v = longint'($urandom_range(2 * span)) - longint'(span);
        return v[FIELD_W-1:0];
    endfunction

    task automatic queue_item(t_kind k, logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
                              logic [FIELD_W-1:0] qx, logic [FIELD_W-1:0] qy, logic last);
        poly_item_t it;
        it.kind = k;
        it.px   = px;
        it.py   = py;
        it.qx   = qx;
        it.qy   = qy;
        it.last = last;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // one segment, then one or two polygons; vertex q fields carry junk
    task automatic queue_query(int unsigned span);
        int unsigned npoly, nv;
        queue_item(KIND_START, rnd_coord(span), rnd_coord(span),
                   rnd_coord(span), rnd_coord(span), $urandom_range(1));
        npoly = ($urandom_range(3) == 0) ? 2 : 1;
        for (int p = 0; p < npoly; p++) begin
            nv = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
            for (int v = 0; v < nv; v++)
                queue_item(KIND_VERTEX, rnd_coord(span), rnd_coord(span),
                           $urandom, $urandom, v == nv - 1);
        end
    endtask

    task automatic queue_random(int unsigned target);
        int unsigned stop_at, r;
        stop_at = items_queued + target;
        while (items_queued < stop_at) begin
            r = $urandom_range(99);
            if (r < 10) begin
                // noise: any kind, any bits
                queue_item(t_kind'($urandom_range(1)), $urandom, $urandom,
                           $urandom, $urandom, $urandom_range(1));
            end else if (r < 20) begin
                queue_query(0);
            end else if (r < 30) begin
                queue_query(64);
            end else begin
                queue_query(1 << $urandom_range(8, 30));
            end
        end
    endtask

    task automatic queue_directed();
        localparam logic [FIELD_W-1:0] ONE = 32'h0001_0000;
        localparam logic [FIELD_W-1:0] NEG = 32'hFFFF_0000;
        localparam logic [FIELD_W-1:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [FIELD_W-1:0] MINV = 32'h8000_0000;
        // vertex with no segment loaded yet
        queue_item(KIND_VERTEX, ONE, NEG, MAXV, MINV, 1'b0);
        queue_item(KIND_VERTEX, NEG, ONE, '0, '0, 1'b1);
        // last flag on a start is ignored; horizontal segment through a square with corners at +/-1
        queue_item(KIND_START, 32'hFFFE_0000, '0, 32'h0002_0000, '0, 1'b1);
        queue_item(KIND_VERTEX, NEG, NEG, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, ONE, NEG, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, ONE, ONE, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, NEG, ONE, '0, '0, 1'b1);
        // same segment, single-vertex polygon
        queue_item(KIND_VERTEX, '0, '0, '0, '0, 1'b1);
        // segment crossing a corner: equal t on the polygon sides that meet there
        queue_item(KIND_START, 32'hFFFE_0000, 32'hFFFE_0000, 32'h0002_0000,
                   32'h0002_0000, 1'b0);
        queue_item(KIND_VERTEX, NEG, NEG, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, ONE, NEG, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, NEG, ONE, '0, '0, 1'b1);
        // edge parallel to segment: zero cross product
        queue_item(KIND_START, '0, '0, 32'h0004_0000, '0, 1'b0);
        queue_item(KIND_VERTEX, '0, '0, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, ONE, '0, '0, '0, 1'b1);
        // extreme coordinates
        queue_item(KIND_START, MINV, MINV, MAXV, MAXV, 1'b0);
        queue_item(KIND_VERTEX, MAXV, MINV, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, MINV, MAXV, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, MAXV, MAXV, '1, '1, 1'b1);
        queue_item(KIND_START, MAXV, MINV, MINV, MAXV, 1'b0);
        queue_item(KIND_VERTEX, MINV, MINV, '0, '0, 1'b0);
        queue_item(KIND_VERTEX, MAXV, MAXV, '0, '0, 1'b1);
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !i_in_valid && expected_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [EPS_W-1:0] value);
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [EPS_W-1:0] eps_set[6];
        int unsigned idle_set[6][2];
        eps_set  = '{EPS_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1 << 20, 32'd0, 32'd66};
        idle_set = '{'{0, 0}, '{72, 0}, '{0, 72}, '{6, 6}, '{72, 72}, '{0, 0}};
        eps_set[4] = $urandom;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            // the first phase runs on the reset threshold
            if (ph > 0) write_eps(eps_set[ph]);
            send_idle_pct  = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            if (ph == 0) queue_directed();
            queue_random(ph == 2 ? 120 : 280);
            wait_idle();
        end
        $display("%0d items accepted over six threshold/idling phases",
                 items_taken);
        $display("%0d polygon results checked, %0d of them hits", results_seen, hits_seen);
        if (errors == 0 && expected_hits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
